// ----- sv/dtt_pkg.sv -----
// shared types and constants of the deadline timer table
// no dependencies; every other file refers to this package by scoped names
`default_nettype none

package dtt_pkg;

	localparam int TIMER_SLOTS = 16;
	localparam int SLOT_W      = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
	localparam int TREE_LVLS   = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
	localparam int TREE_LEAVES = 1 << TREE_LVLS;
	localparam int CNT_W       = (TREE_LVLS > 1) ? $clog2(TREE_LVLS) : 1;

	localparam int NAME_W = 32;
	localparam int DL_W   = 64;

	typedef enum logic [1:0] {
		OP_ARM     = 2'd0,
		OP_CANCEL  = 2'd1,
		OP_DISARM  = 2'd2,
		OP_DESTROY = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NOT_TIMER = 2'd1,
		ST_FULL      = 2'd2
	} st_t;

	// controller commands to the datapath
	typedef struct packed {
		logic capture;
		logic lookup;
		logic update;
	} cmd_t;

	// one candidate of the earliest-deadline search, all zero when not valid
	typedef struct packed {
		logic              valid;
		logic [NAME_W-1:0] name;
		logic [DL_W-1:0]   deadline;
	} node_t;

endpackage

`default_nettype wire

// ----- sv/dtt_ctrl.sv -----
// controller state machine of the deadline timer table
// depends on dtt_pkg; drives the datapath through dtt_pkg::cmd_t
`default_nettype none

module dtt_ctrl (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         start,
	output logic              busy,
	output logic              done,
	output dtt_pkg::cmd_t     cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_LOOK,
		S_UPD,
		S_MIN,
		S_OUT
	} state_t;

	state_t                    state_q;
	logic                      busy_q;
	logic                      done_q;
	logic [dtt_pkg::CNT_W-1:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
			cnt_q   <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q <= S_LOOK;
						busy_q  <= 1'b1;
					end
				end
				S_LOOK: begin
					state_q <= S_UPD;
				end
				S_UPD: begin
					state_q <= S_MIN;
					cnt_q   <= '0;
				end
				S_MIN: begin
					if (cnt_q == dtt_pkg::CNT_W'(dtt_pkg::TREE_LVLS - 1)) begin
						state_q <= S_OUT;
						busy_q  <= 1'b0;
						done_q  <= 1'b1;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_OUT: begin
					if (start) begin
						state_q <= S_LOOK;
						busy_q  <= 1'b1;
					end else begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy        = busy_q;
	assign done        = done_q;
	assign cmd.capture = start && !busy_q;
	assign cmd.lookup  = (state_q == S_LOOK);
	assign cmd.update  = (state_q == S_UPD);

`ifndef SYNTHESIS
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("busy not raised after an accepted item");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while busy");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe longer than one cycle");

	a_update_after_lookup: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.update |-> $past(cmd.lookup))
		else $error("table update without a lookup before it");
`endif

endmodule

`default_nettype wire

// ----- sv/dtt_table.sv -----
// timer slot storage with name lookup, free slot search and update
// depends on dtt_pkg; feeds the leaves of dtt_min_tree
`default_nettype none

module dtt_table (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire dtt_pkg::cmd_t                 cmd,
	input  wire logic [1:0]                    opcode,
	input  wire logic [dtt_pkg::NAME_W-1:0]    timer_name,
	input  wire logic [dtt_pkg::DL_W-1:0]      deadline,
	input  wire logic                          is_timer,
	output dtt_pkg::st_t                       status,
	output logic                               already_armed,
	output logic [dtt_pkg::DL_W-1:0]           removed_deadline,
	output dtt_pkg::node_t                     leaves [dtt_pkg::TREE_LEAVES]
);

	localparam int N = dtt_pkg::TIMER_SLOTS;

	// captured item
	dtt_pkg::op_t                 op_q;
	logic [dtt_pkg::NAME_W-1:0]   name_q;
	logic [dtt_pkg::DL_W-1:0]     dl_q;
	logic                         timer_q;

	// slots
	logic [N-1:0]                 valid_q;
	logic [dtt_pkg::NAME_W-1:0]   slot_name_q [N];
	logic [dtt_pkg::DL_W-1:0]     slot_dl_q [N];

	// lookup results
	logic                         hit_q;
	logic [dtt_pkg::SLOT_W-1:0]   hit_idx_q;
	logic [dtt_pkg::DL_W-1:0]     hit_dl_q;
	logic                         free_any_q;
	logic [dtt_pkg::SLOT_W-1:0]   free_idx_q;

	// result fields
	dtt_pkg::st_t                 status_q;
	logic                         was_q;
	logic [dtt_pkg::DL_W-1:0]     removed_q;

	logic [N-1:0]                 match;
	logic [N-1:0]                 free_vec;
	logic [N-1:0]                 free_oh;
	logic [dtt_pkg::SLOT_W-1:0]   hit_idx;
	logic [dtt_pkg::SLOT_W-1:0]   free_idx;
	logic [dtt_pkg::DL_W-1:0]     hit_dl;

	always_comb begin
		hit_idx  = '0;
		free_idx = '0;
		hit_dl   = '0;
		for (int i = 0; i < N; i++) begin
			match[i] = valid_q[i] && (slot_name_q[i] == name_q);
		end
		free_vec = ~valid_q;
		free_oh  = free_vec & (~free_vec + 1'b1);
		for (int i = 0; i < N; i++) begin
			if (match[i]) begin
				hit_idx = hit_idx | dtt_pkg::SLOT_W'(i);
				hit_dl  = hit_dl | slot_dl_q[i];
			end
			if (free_oh[i]) begin
				free_idx = free_idx | dtt_pkg::SLOT_W'(i);
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q    <= dtt_pkg::op_t'(opcode);
			name_q  <= timer_name;
			dl_q    <= deadline;
			timer_q <= is_timer;
		end
		if (cmd.lookup) begin
			hit_q      <= |match;
			hit_idx_q  <= hit_idx;
			hit_dl_q   <= hit_dl;
			free_any_q <= |free_vec;
			free_idx_q <= free_idx;
		end
		if (cmd.update) begin
			status_q  <= dtt_pkg::ST_OK;
			was_q     <= 1'b0;
			removed_q <= '0;
			unique case (op_q)
				dtt_pkg::OP_ARM: begin
					if (!timer_q) begin
						status_q <= dtt_pkg::ST_NOT_TIMER;
					end else if (hit_q) begin
						slot_dl_q[hit_idx_q] <= dl_q;
						was_q                <= 1'b1;
					end else if (free_any_q) begin
						slot_name_q[free_idx_q] <= name_q;
						slot_dl_q[free_idx_q]   <= dl_q;
					end else begin
						status_q <= dtt_pkg::ST_FULL;
					end
				end
				dtt_pkg::OP_CANCEL: begin
					if (hit_q) begin
						removed_q <= hit_dl_q;
					end
				end
				dtt_pkg::OP_DISARM: begin
				end
				dtt_pkg::OP_DESTROY: begin
					if (!timer_q) begin
						status_q <= dtt_pkg::ST_NOT_TIMER;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (cmd.update) begin
			unique case (op_q)
				dtt_pkg::OP_ARM: begin
					if (timer_q && !hit_q && free_any_q) begin
						valid_q[free_idx_q] <= 1'b1;
					end
				end
				dtt_pkg::OP_CANCEL, dtt_pkg::OP_DISARM: begin
					if (hit_q) begin
						valid_q[hit_idx_q] <= 1'b0;
					end
				end
				dtt_pkg::OP_DESTROY: begin
					if (timer_q && hit_q) begin
						valid_q[hit_idx_q] <= 1'b0;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// leaves of the search tree, zero when empty or padding
	always_comb begin
		for (int i = 0; i < dtt_pkg::TREE_LEAVES; i++) begin
			leaves[i] = '0;
		end
		for (int i = 0; i < N; i++) begin
			if (valid_q[i]) begin
				leaves[i].valid    = 1'b1;
				leaves[i].name     = slot_name_q[i];
				leaves[i].deadline = slot_dl_q[i];
			end
		end
	end

	assign status           = status_q;
	assign already_armed    = was_q;
	assign removed_deadline = removed_q;

`ifndef SYNTHESIS
	a_unique_names: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(match))
		else $error("timer name held by more than one slot");
`endif

endmodule

`default_nettype wire

// ----- sv/dtt_min_tree.sv -----
// registered compare tree that finds the earliest armed deadline
// depends on dtt_pkg; one tree level settles per clock
`default_nettype none

module dtt_min_tree (
	input  wire logic           clk,
	input  wire dtt_pkg::node_t leaves [dtt_pkg::TREE_LEAVES],
	output dtt_pkg::node_t      root
);

	localparam int L = dtt_pkg::TREE_LEAVES;

	// heap order: node 1 is the root, node i has children 2i and 2i+1
	dtt_pkg::node_t node_q [1:L-1];

	function automatic dtt_pkg::node_t pick(input dtt_pkg::node_t a, input dtt_pkg::node_t b);
		dtt_pkg::node_t r;
		if (!a.valid) begin
			r = b;
		end else if (!b.valid) begin
			r = a;
		end else if ((b.deadline < a.deadline) ||
				((b.deadline == a.deadline) && (b.name < a.name))) begin
			r = b;
		end else begin
			r = a;
		end
		return r;
	endfunction

	for (genvar i = 1; i < L; i++) begin : g_node
		dtt_pkg::node_t lo;
		dtt_pkg::node_t hi;
		if (2 * i >= L) begin : g_leaf
			assign lo = leaves[2 * i - L];
			assign hi = leaves[2 * i + 1 - L];
		end else begin : g_inner
			assign lo = node_q[2 * i];
			assign hi = node_q[2 * i + 1];
		end
		always_ff @(posedge clk) begin
			node_q[i] <= pick(lo, hi);
		end
	end

	assign root = node_q[1];

endmodule

`default_nettype wire

// ----- sv/deadline_timer_table_core.sv -----
// top level of the deadline timer table
// depends on dtt_pkg, dtt_ctrl, dtt_table and dtt_min_tree
`default_nettype none

// A table of up to 16 armed timers, each a 32-bit name and a 64-bit deadline.
// command channel: an item (opcode, timer_name, deadline, is_timer) is taken
//   at a rising edge where start is high and busy is low
// result channel: done is high for exactly one cycle; status, already_armed,
//   removed_deadline, any_armed, earliest_name and earliest_deadline are
//   valid in that cycle and hold until the next item updates them
// sequence: after the accepting edge the item is looked up by name against
//   all slots, then the table is written, then the levels of the registered
//   compare tree that finds the earliest deadline are registered in turn;
//   done rises as the tree root is registered
// busy drops in the done cycle, so a new item can be taken at the edge that
//   ends it; no new item is taken while an earlier one is still in progress
// reset: arst_n clears all valid bits at once, so the table starts empty;
//   no clearing sweep is needed and the first item can be taken right away
// the receiver cannot stall: each result is shown once and must be taken
//   in its done cycle
// every result reports the earliest armed timer, smallest name on equal
//   deadlines, or all zero when no timer is armed
module deadline_timer_table_core (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	output logic                            busy,
	input  wire logic [1:0]                 opcode,
	input  wire logic [dtt_pkg::NAME_W-1:0] timer_name,
	input  wire logic [dtt_pkg::DL_W-1:0]   deadline,
	input  wire logic                       is_timer,
	output logic                            done,
	output logic [1:0]                      status,
	output logic                            already_armed,
	output logic [dtt_pkg::DL_W-1:0]        removed_deadline,
	output logic                            any_armed,
	output logic [dtt_pkg::NAME_W-1:0]      earliest_name,
	output logic [dtt_pkg::DL_W-1:0]        earliest_deadline
);

	dtt_pkg::cmd_t  cmd;
	dtt_pkg::st_t   st;
	dtt_pkg::node_t leaves [dtt_pkg::TREE_LEAVES];
	dtt_pkg::node_t root;

	// sequencer: capture, lookup, update, tree settle, result strobe
	dtt_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd)
	);

	// slot storage, lookup and per-item result fields
	dtt_table u_table (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.opcode           (opcode),
		.timer_name       (timer_name),
		.deadline         (deadline),
		.is_timer         (is_timer),
		.status           (st),
		.already_armed    (already_armed),
		.removed_deadline (removed_deadline),
		.leaves           (leaves)
	);

	// earliest deadline search; empty leaves are all zero so the root is too
	dtt_min_tree u_tree (
		.clk    (clk),
		.leaves (leaves),
		.root   (root)
	);

	assign status            = st;
	assign any_armed         = root.valid;
	assign earliest_name     = root.name;
	assign earliest_deadline = root.deadline;

endmodule

`default_nettype wire

// ----- tb/tb_deadline_timer_table_core.sv -----
// self-checking testbench of the deadline timer table core
// needs dtt_pkg and deadline_timer_table_core; predicts every result in a small class
`timescale 1ns / 100ps

module tb_deadline_timer_table_core;

	localparam int CYCLE_LIMIT  = 400000;
	localparam int PHASE_ITEMS  = 200;
	localparam int RANDOM_PHASES = 7;
	localparam int POOL_MAX     = 32;

	// one result as the core reports it
	typedef struct packed {
		dtt_pkg::st_t               status;
		logic                       already_armed;
		logic [dtt_pkg::DL_W-1:0]   removed_deadline;
		logic                       any_armed;
		logic [dtt_pkg::NAME_W-1:0] earliest_name;
		logic [dtt_pkg::DL_W-1:0]   earliest_deadline;
	} timer_result_t;

	// shadow copy of the timer table plus the results still owed by the core
	class timer_table_sb;
		bit                         armed[dtt_pkg::TIMER_SLOTS];
		logic [dtt_pkg::NAME_W-1:0] armed_name[dtt_pkg::TIMER_SLOTS];
		logic [dtt_pkg::DL_W-1:0]   armed_deadline[dtt_pkg::TIMER_SLOTS];
		timer_result_t              expected_results[$];
		int unsigned                mismatches;

		function new();
			foreach (armed[i]) begin
				armed[i] = 1'b0;
				armed_name[i] = '0;
				armed_deadline[i] = '0;
			end
			mismatches = 0;
		endfunction

		// update the shadow table with one item and work out its result
		function timer_result_t apply_command(dtt_pkg::op_t op,
			logic [dtt_pkg::NAME_W-1:0] nm, logic [dtt_pkg::DL_W-1:0] dl, logic tmr);
			timer_result_t r;
			int hit;
			int free_idx;
			r = '0;
			hit = -1;
			free_idx = -1;
			for (int i = 0; i < dtt_pkg::TIMER_SLOTS; i++) begin
				if (hit < 0 && armed[i] && armed_name[i] == nm)
					hit = i;
				if (free_idx < 0 && !armed[i])
					free_idx = i;
			end
			case (op)
				dtt_pkg::OP_ARM: begin
					if (!tmr)
						r.status = dtt_pkg::ST_NOT_TIMER;
					else if (hit >= 0) begin
						armed_deadline[hit] = dl;
						r.already_armed = 1'b1;
					end else if (free_idx < 0)
						r.status = dtt_pkg::ST_FULL;
					else begin
						armed[free_idx] = 1'b1;
						armed_name[free_idx] = nm;
						armed_deadline[free_idx] = dl;
					end
				end
				dtt_pkg::OP_CANCEL: begin
					if (hit >= 0) begin
						r.removed_deadline = armed_deadline[hit];
						armed[hit] = 1'b0;
					end
				end
				dtt_pkg::OP_DISARM: begin
					if (hit >= 0)
						armed[hit] = 1'b0;
				end
				default: begin
					if (!tmr)
						r.status = dtt_pkg::ST_NOT_TIMER;
					else if (hit >= 0)
						armed[hit] = 1'b0;
				end
			endcase
			// earliest deadline, smaller name on a tie
			for (int i = 0; i < dtt_pkg::TIMER_SLOTS; i++) begin
				if (armed[i] && (!r.any_armed || armed_deadline[i] < r.earliest_deadline ||
					(armed_deadline[i] == r.earliest_deadline &&
					armed_name[i] < r.earliest_name))) begin
					r.any_armed = 1'b1;
					r.earliest_deadline = armed_deadline[i];
					r.earliest_name = armed_name[i];
				end
			end
			return r;
		endfunction

		function void note_command(dtt_pkg::op_t op, logic [dtt_pkg::NAME_W-1:0] nm,
			logic [dtt_pkg::DL_W-1:0] dl, logic tmr);
			expected_results.push_back(apply_command(op, nm, dl, tmr));
		endfunction

		function void check_result(timer_result_t got);
			timer_result_t want;
			if (expected_results.size() == 0) begin
				if (mismatches < 10)
					$display("unexpected result at %0t: status %0d name %h dl %h",
						$realtime, got.status, got.earliest_name, got.earliest_deadline);
				mismatches++;
			end else begin
				want = expected_results.pop_front();
				if (got.status !== want.status || got.already_armed !== want.already_armed ||
					got.removed_deadline !== want.removed_deadline ||
					got.any_armed !== want.any_armed ||
					got.earliest_name !== want.earliest_name ||
					got.earliest_deadline !== want.earliest_deadline) begin
					if (mismatches < 10) begin
						$display("result mismatch at %0t", $realtime);
						$display("  expected st %0d was %0b rm %h any %0b name %h dl %h",
							want.status, want.already_armed, want.removed_deadline,
							want.any_armed, want.earliest_name, want.earliest_deadline);
						$display("  actual   st %0d was %0b rm %h any %0b name %h dl %h",
							got.status, got.already_armed, got.removed_deadline,
							got.any_armed, got.earliest_name, got.earliest_deadline);
					end
					mismatches++;
				end
			end
		endfunction
	endclass

	logic                       clk;
	logic                       arst_n;
	logic                       start;
	logic                       busy;
	logic [1:0]                 opcode;
	logic [dtt_pkg::NAME_W-1:0] timer_name;
	logic [dtt_pkg::DL_W-1:0]   deadline;
	logic                       is_timer;
	logic                       done;
	logic [1:0]                 status;
	logic                       already_armed;
	logic [dtt_pkg::DL_W-1:0]   removed_deadline;
	logic                       any_armed;
	logic [dtt_pkg::NAME_W-1:0] earliest_name;
	logic [dtt_pkg::DL_W-1:0]   earliest_deadline;

	timer_table_sb              sb;
	bit                         idle_on;
	logic [dtt_pkg::NAME_W-1:0] name_pool[POOL_MAX];
	int unsigned                cycles;

	deadline_timer_table_core uut (
		.clk               (clk),
		.arst_n            (arst_n),
		.start             (start),
		.busy              (busy),
		.opcode            (opcode),
		.timer_name        (timer_name),
		.deadline          (deadline),
		.is_timer          (is_timer),
		.done              (done),
		.status            (status),
		.already_armed     (already_armed),
		.removed_deadline  (removed_deadline),
		.any_armed         (any_armed),
		.earliest_name     (earliest_name),
		.earliest_deadline (earliest_deadline)
	);

	// 20 ns clock
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// every done pulse is one result, taken at the edge that ends its cycle
	always @(posedge clk) begin
		if (arst_n && done === 1'b1)
			sb.check_result({dtt_pkg::st_t'(status), already_armed, removed_deadline,
				any_armed, earliest_name, earliest_deadline});
	end

	// hard stop in case the core hangs or never answers
	initial begin
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("deadline_timer_table_core: mismatch");
		$finish;
	end

	// present one item from a falling edge and hold it until the core takes it;
	// the random gap in front lets start rise at any point of the core's work
	task automatic send_cmd(dtt_pkg::op_t op, logic [dtt_pkg::NAME_W-1:0] nm,
		logic [dtt_pkg::DL_W-1:0] dl, logic tmr);
		int gap;
		gap = idle_on ? $urandom_range(0, 8) : 0;
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		opcode     <= op;
		timer_name <= nm;
		deadline   <= dl;
		is_timer   <= tmr;
		start      <= 1'b1;
		// taken at the first rising edge with busy low
		@(posedge clk);
		while (busy !== 1'b0)
			@(posedge clk);
		sb.note_command(op, nm, dl, tmr);
		@(negedge clk);
	endtask

	// hold off the sender until every owed result has come back
	task automatic drain_results();
		start <= 1'b0;
		@(negedge clk);
		while (sb.expected_results.size() != 0)
			@(negedge clk);
	endtask

	// random item, mostly names from the current pool so arms and removals meet
	task automatic random_cmd(int pool_n);
		int                         pick;
		dtt_pkg::op_t               op;
		logic [dtt_pkg::NAME_W-1:0] nm;
		logic [dtt_pkg::DL_W-1:0]   dl;
		logic                       tmr;
		pick = $urandom_range(0, 99);
		if (pick < 40)
			op = dtt_pkg::OP_ARM;
		else if (pick < 60)
			op = dtt_pkg::OP_CANCEL;
		else if (pick < 80)
			op = dtt_pkg::OP_DISARM;
		else
			op = dtt_pkg::OP_DESTROY;
		nm = ($urandom_range(0, 15) == 0) ? $urandom : name_pool[$urandom_range(0, pool_n - 1)];
		case ($urandom_range(0, 3))
			0: dl = {$urandom, $urandom};
			1: dl = 64'($urandom_range(0, 7));          // frequent ties near zero
			2: dl = ~64'($urandom_range(0, 3));         // near the top of the range
			default: dl = {32'($urandom_range(0, 3)), $urandom};
		endcase
		tmr = ($urandom_range(0, 9) != 0);
		send_cmd(op, nm, dl, tmr);
	endtask

	initial begin
		int pool_n;
		sb = new();
		idle_on    = 1'b1;
		arst_n     = 1'b0;
		start      = 1'b0;
		opcode     = dtt_pkg::OP_ARM;
		timer_name = '0;
		deadline   = '0;
		is_timer   = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: empty table, non-timer rejects
		send_cmd(dtt_pkg::OP_CANCEL, 32'h1234_5678, '1, 1'b1);
		send_cmd(dtt_pkg::OP_DESTROY, 32'h1234_5678, '0, 1'b0);
		send_cmd(dtt_pkg::OP_ARM, 32'h0000_0005, 64'd100, 1'b0);
		// fill every slot: names 0 up to all ones, ties at both deadline extremes
		for (int i = 0; i < dtt_pkg::TIMER_SLOTS; i++)
			send_cmd(dtt_pkg::OP_ARM, i * 32'h1111_1111,
				(i < 2) ? '1 : (i >= 14) ? '0 : {$urandom, $urandom}, 1'b1);
		// new name on a full table, then overwrite of an existing one
		send_cmd(dtt_pkg::OP_ARM, 32'h0000_0007, 64'd1, 1'b1);
		send_cmd(dtt_pkg::OP_ARM, 32'h0000_0000, '0, 1'b1);
		// cancel ignores the object kind
		send_cmd(dtt_pkg::OP_CANCEL, 32'h1111_1111, '0, 1'b0);
		// destroy of a present non-timer is refused, then done for real
		send_cmd(dtt_pkg::OP_DESTROY, 32'h2222_2222, '0, 1'b0);
		send_cmd(dtt_pkg::OP_DESTROY, 32'h2222_2222, '0, 1'b1);
		send_cmd(dtt_pkg::OP_DISARM, 32'h0000_0000, '1, 1'b0);
		send_cmd(dtt_pkg::OP_DISARM, 32'h0000_0000, '1, 1'b1);
		drain_results();

		// random phases: pool size sets how often the table fills up
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			case (ph)
				0: pool_n = 4;
				1: pool_n = 18;
				2: pool_n = 32;
				3: pool_n = 10;
				4: pool_n = 24;
				5: pool_n = 2;
				default: pool_n = 32;
			endcase
			// back-to-back items in two of the phases
			idle_on = (ph != 2 && ph != 5);
			for (int i = 0; i < POOL_MAX; i++) begin
				case ($urandom_range(0, 2))
					0: name_pool[i] = $urandom;
					1: name_pool[i] = 32'(i);
					default: name_pool[i] = ~32'(i);
				endcase
			end
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				random_cmd(pool_n);
				if ($urandom_range(0, 63) == 0)
					drain_results();
			end
			drain_results();
		end

		// let any stray done pulse show up before the verdict
		repeat (16) @(negedge clk);
		if (sb.mismatches == 0 && sb.expected_results.size() == 0)
			$display("deadline_timer_table_core: match");
		else
			$display("deadline_timer_table_core: mismatch");
		$finish;
	end

endmodule
